// ----- src/orf_pkg.sv -----
// orf_pkg: shared types and constants of the overwriting ring fifo
// no dependencies; imported by the interfaces, orf_ctrl, orf_dpath, the top level and the checker
`default_nettype none

package orf_pkg;

  // width of the used-depth register, pop count and occupancy fields
  localparam int CNT_W = 7;

  // used depth after reset
  localparam logic [CNT_W-1:0] USED_DEPTH_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_NODATA = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    cfg_wr;
    logic    push;
    logic    flush;
    logic    flag;
    status_t flag_status;
    logic    start_pop;
    logic    start_peek;
    logic    advance;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic count_zero;
    logic count_over;
    logic fill_zero;
    logic last_elem;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/orf_ifs.sv -----
// orf_ifs: valid/ready channel interfaces of the overwriting ring fifo
// depends on orf_pkg
`default_nettype none

interface orf_req_if import orf_pkg::*; #(parameter int DATA_WIDTH = 8);
  logic                  valid;
  logic                  ready;
  cmd_t                  command;
  logic [DATA_WIDTH-1:0] data_in;
  logic [CNT_W-1:0]      pop_count;

  modport source (output valid, command, data_in, pop_count, input ready);
  modport sink   (input valid, command, data_in, pop_count, output ready);
endinterface

interface orf_rsp_if import orf_pkg::*; #(parameter int DATA_WIDTH = 8);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  status_t               status;
  logic                  last;
  logic                  dropped_oldest;
  logic [CNT_W-1:0]      occupancy;
  logic                  is_empty;
  logic                  is_full;

  modport source (output valid, data_out, status, last, dropped_oldest, occupancy,
                  is_empty, is_full, input ready);
  modport sink   (input valid, data_out, status, last, dropped_oldest, occupancy,
                  is_empty, is_full, output ready);
endinterface

interface orf_cfg_if import orf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] used_depth;

  modport source (output valid, used_depth, input ready);
  modport sink   (input valid, used_depth, output ready);
endinterface

`default_nettype wire

// ----- src/orf_ram.sv -----
// orf_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module orf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/orf_ctrl.sv -----
// orf_ctrl: command decoder and stream sequencer of the overwriting ring fifo
// depends on orf_pkg
`default_nettype none

module orf_ctrl import orf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  cmd_t     req_command,
  input  logic     cfg_valid,
  input  dp_stat_t stat,
  output logic     req_ready,
  output logic     cfg_ready,
  output ctl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.flag_status = ST_OK;
    req_ready  = (state == S_IDLE) && stat.out_free;
    // depth writes wait for a quiet request side
    cfg_ready  = (state == S_IDLE) && !req_valid;
    accept     = req_valid && req_ready;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_command)
            CMD_PUSH:  cmd.push = 1'b1;
            CMD_FLUSH: cmd.flush = 1'b1;
            CMD_POP: begin
              if (stat.count_zero) begin
                cmd.flag        = 1'b1;
                cmd.flag_status = ST_NODATA;
              end else if (stat.count_over) begin
                cmd.flag        = 1'b1;
                cmd.flag_status = ST_SHORT;
              end else begin
                cmd.start_pop = 1'b1;
                state_next    = S_STREAM;
              end
            end
            CMD_PEEK: begin
              if (stat.fill_zero) begin
                cmd.flag        = 1'b1;
                cmd.flag_status = ST_NODATA;
              end else begin
                cmd.start_peek = 1'b1;
                state_next     = S_STREAM;
              end
            end
            default: cmd.flush = 1'b1;
          endcase
        end
      end
      S_STREAM: begin
        cmd.advance = stat.out_free;
        if (stat.out_free && stat.last_elem) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/orf_dpath.sv -----
// orf_dpath: pointers, fill count, element ram and result register
// depends on orf_pkg and orf_ram
`default_nettype none

module orf_dpath import orf_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  input  logic [DATA_WIDTH-1:0] data_in,
  input  logic [CNT_W-1:0]      pop_count,
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic                  out_ready,
  output dp_stat_t              stat,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_data,
  output status_t               out_status,
  output logic                  out_last,
  output logic                  out_dropped,
  output logic [CNT_W-1:0]      out_occ,
  output logic                  out_empty,
  output logic                  out_full
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [CNT_W-1:0]      used_depth;
  logic [CNT_W-1:0]      eff_depth;
  logic [PTR_W-1:0]      rd_ptr;
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      cursor;
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      remaining;
  logic                  pop_mode;
  logic                  full_now;
  logic [CNT_W-1:0]      fill_push;
  logic [CNT_W-1:0]      occ_src;
  logic                  load;
  logic                  ram_re;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [PTR_W-1:0]      cursor_inc;

  // ring step with wrap at the effective depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] lim);
    logic [PTR_W:0] p1;
    p1 = {1'b0, p} + 1'b1;
    if (32'(p1) >= 32'(lim)) begin
      return '0;
    end
    return p1[PTR_W-1:0];
  endfunction

  // zero acts as one, above the built depth acts as the built depth
  always_comb begin
    if (used_depth == '0) begin
      eff_depth = CNT_W'(1);
    end else if (32'(used_depth) > DEPTH) begin
      eff_depth = CNT_W'(DEPTH);
    end else begin
      eff_depth = used_depth;
    end
  end

  assign full_now   = (fill == eff_depth);
  assign fill_push  = full_now ? fill : fill + 1'b1;
  assign cursor_inc = ptr_inc(cursor, eff_depth);
  assign load       = cmd.push || cmd.flush || cmd.flag || cmd.advance;

  always_comb begin
    occ_src = fill;
    if (cmd.flush) begin
      occ_src = '0;
    end else if (cmd.push) begin
      occ_src = fill_push;
    end
  end

  assign ram_re    = cmd.start_pop || cmd.start_peek || cmd.advance;
  assign ram_raddr = cmd.advance ? cursor_inc : rd_ptr;

  orf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_ptr),
    .wdata (data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.count_zero = (pop_count == '0);
  assign stat.count_over = (pop_count > fill);
  assign stat.fill_zero  = (fill == '0);
  assign stat.last_elem  = (remaining == CNT_W'(1));

  // ring state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      used_depth <= USED_DEPTH_RST;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.cfg_wr) begin
        used_depth <= cfg_data;
        rd_ptr     <= '0;
        wr_ptr     <= '0;
        fill       <= '0;
      end else if (cmd.push) begin
        if (full_now) begin
          rd_ptr <= ptr_inc(rd_ptr, eff_depth);
        end
        wr_ptr <= ptr_inc(wr_ptr, eff_depth);
        fill   <= fill_push;
      end else if (cmd.flush) begin
        rd_ptr <= '0;
        wr_ptr <= '0;
        fill   <= '0;
      end else if (cmd.start_pop) begin
        fill <= fill - pop_count;
      end else if (cmd.advance && stat.last_elem && pop_mode) begin
        rd_ptr <= cursor_inc;
      end
    end
  end

  // stream cursor and result payload
  always_ff @(posedge clk) begin
    if (cmd.start_pop || cmd.start_peek) begin
      cursor    <= rd_ptr;
      remaining <= cmd.start_pop ? pop_count : fill;
      pop_mode  <= cmd.start_pop;
    end else if (cmd.advance) begin
      cursor    <= cursor_inc;
      remaining <= remaining - 1'b1;
    end
    if (load) begin
      out_data    <= cmd.advance ? ram_rdata : '0;
      out_status  <= cmd.flag ? cmd.flag_status : ST_OK;
      out_last    <= cmd.advance ? stat.last_elem : 1'b1;
      out_dropped <= cmd.push && full_now;
      out_occ     <= occ_src;
      out_empty   <= (occ_src == '0);
      out_full    <= (occ_src == eff_depth);
    end
  end

endmodule

`default_nettype wire

// ----- src/overwriting_ring_fifo.sv -----
// overwriting_ring_fifo: top level of the overwriting ring fifo
// depends on orf_pkg, orf_ifs, orf_ctrl, orf_dpath (and orf_ram below it)
//
//   channel   role   carries
//   -------   ----   --------------------------------------------------------
//   request   sink   command, data_in, pop_count
//   result    source data_out, status, last, dropped_oldest, occupancy, flags
//   cfg       sink   used_depth (write also empties the ring)
//
// push, flush and rejected pops/peeks each give one result
// a pop of n or a peek of n held elements first reads the first element from
// the ram, then streams n results, one per cycle while the result is not stalled
// a new request follows once the last result has been loaded into the result register
// reset clears pointers, fill count and the result valid flag; used depth is 64
// a stalled result holds the stream in place; no element is lost or repeated
// a depth write is taken only between streams and while no request is offered
`default_nettype none

module overwriting_ring_fifo import orf_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input logic      clk,
  input logic      rst,
  orf_req_if.sink  request,
  orf_rsp_if.source result,
  orf_cfg_if.sink  cfg
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // controller: decodes one request at a time, sequences pop and peek streams
  orf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (request.valid),
    .req_command (request.command),
    .cfg_valid   (cfg.valid),
    .stat        (stat),
    .req_ready   (request.ready),
    .cfg_ready   (cfg.ready),
    .cmd         (cmd)
  );

  // datapath: ring pointers, fill count, element ram and result register
  orf_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_in     (request.data_in),
    .pop_count   (request.pop_count),
    .cfg_data    (cfg.used_depth),
    .out_ready   (result.ready),
    .stat        (stat),
    .out_valid   (result.valid),
    .out_data    (result.data_out),
    .out_status  (result.status),
    .out_last    (result.last),
    .out_dropped (result.dropped_oldest),
    .out_occ     (result.occupancy),
    .out_empty   (result.is_empty),
    .out_full    (result.is_full)
  );

endmodule

`default_nettype wire

// ----- src/orf_checker.sv -----
// orf_checker: port-level assertions for the overwriting ring fifo
// depends on orf_pkg; bound to overwriting_ring_fifo at the end of this file
`default_nettype none

module orf_checker import orf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input cmd_t             req_command,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input status_t          rsp_status,
  input logic             rsp_last,
  input logic [CNT_W-1:0] rsp_occupancy
);

  // a push transfer yields one final ok result next cycle
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_PUSH
      |=> rsp_valid && rsp_last && rsp_status == ST_OK)
    else $error("push did not produce a final ok result");

  // a flush transfer yields one final result with an empty ring
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_FLUSH
      |=> rsp_valid && rsp_last && rsp_occupancy == '0)
    else $error("flush did not report an empty ring");

  // no new request while a stream is still delivering
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("request taken in the middle of a stream");

  // a stalled result keeps its status, last flag and occupancy
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready
      |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last) && $stable(rsp_occupancy))
    else $error("stalled result changed");

endmodule

bind overwriting_ring_fifo orf_checker u_orf_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (request.valid),
  .req_ready     (request.ready),
  .req_command   (request.command),
  .rsp_valid     (result.valid),
  .rsp_ready     (result.ready),
  .rsp_status    (result.status),
  .rsp_last      (result.last),
  .rsp_occupancy (result.occupancy)
);

`default_nettype wire
